/* src/lsr_pkg.sv */
// Shared types, codes and defaults for the LIFO stack with reverse unit.
`timescale 1ns / 1ps

package lsr_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int VALUE_BITS     = 32;
    localparam int IDX_BITS       = 6;
    localparam int DEPTH_NOW_BITS = 7;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_POP     = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_REVERSE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]            func;
        logic [VALUE_BITS-1:0] push_value;
        logic [IDX_BITS-1:0]   read_index;
    } in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]     read_value;
        logic [1:0]                status;
        logic [DEPTH_NOW_BITS-1:0] depth_now;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       read;
        logic       rev_start;
        logic       rev_read;
        logic       rev_wr_lo;
        logic       rev_wr_hi;
        logic       out_load_mem;
        logic       out_load_zero;
        logic [1:0] st;
    } dp_cmd_t;

    // Conditions reported by the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic few;
        logic idx_beyond;
        logic rev_last;
    } dp_stat_t;

endpackage

/* src/lsr_ctrl.sv */
// Controller state machine for the LIFO stack with reverse unit.
`timescale 1ns / 1ps

module lsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  lsr_pkg::dp_stat_t stat,
    output lsr_pkg::dp_cmd_t  cmd,
    output logic              m_valid,
    input  logic              m_ready
);
    import lsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEM_WAIT,
        S_REV_READ,
        S_REV_WR_LO,
        S_REV_WR_HI
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.st       = ST_OK;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_PUSH: begin
                            cmd.out_load_zero = 1'b1;
                            m_valid_next      = 1'b1;
                            if (stat.full) begin
                                cmd.st = ST_FULL;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            if (stat.empty) begin
                                cmd.out_load_zero = 1'b1;
                                cmd.st            = ST_EMPTY;
                                m_valid_next      = 1'b1;
                            end else begin
                                cmd.pop    = 1'b1;
                                state_next = S_MEM_WAIT;
                            end
                        end
                        FUNC_READ: begin
                            if (stat.empty) begin
                                cmd.out_load_zero = 1'b1;
                                cmd.st            = ST_EMPTY;
                                m_valid_next      = 1'b1;
                            end else if (stat.idx_beyond) begin
                                cmd.out_load_zero = 1'b1;
                                cmd.st            = ST_RANGE;
                                m_valid_next      = 1'b1;
                            end else begin
                                cmd.read   = 1'b1;
                                state_next = S_MEM_WAIT;
                            end
                        end
                        default: begin
                            // A stack of zero or one entry is already its own reverse.
                            if (stat.few) begin
                                cmd.out_load_zero = 1'b1;
                                m_valid_next      = 1'b1;
                            end else begin
                                cmd.rev_start = 1'b1;
                                state_next    = S_REV_READ;
                            end
                        end
                    endcase
                end
            end
            S_MEM_WAIT: begin
                cmd.out_load_mem = 1'b1;
                m_valid_next     = 1'b1;
                state_next       = S_IDLE;
            end
            S_REV_READ: begin
                cmd.rev_read = 1'b1;
                state_next   = S_REV_WR_LO;
            end
            S_REV_WR_LO: begin
                cmd.rev_wr_lo = 1'b1;
                state_next    = S_REV_WR_HI;
            end
            S_REV_WR_HI: begin
                cmd.rev_wr_hi = 1'b1;
                if (stat.rev_last) begin
                    cmd.out_load_zero = 1'b1;
                    m_valid_next      = 1'b1;
                    state_next        = S_IDLE;
                end else begin
                    state_next = S_REV_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_valid_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_valid_reg)
        else $error("result valid while an operation is still in progress");

    a_mem_wait_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEM_WAIT) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("pop or read did not produce a result after the memory read");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("stalled result was lost or a new operation started");
`endif

endmodule

/* src/lsr_dpath.sv */
// Datapath of the LIFO stack: entry memory, entry count, swap pointers, result register.
`timescale 1ns / 1ps

module lsr_dpath #(
    parameter int DEPTH     = lsr_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = lsr_pkg::WORD_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsr_pkg::in_t      s_data,
    input  lsr_pkg::dp_cmd_t  cmd,
    output lsr_pkg::dp_stat_t stat,
    output lsr_pkg::out_t     m_data
);
    import lsr_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     lo_reg, lo_next;
    logic [ADDR_W-1:0]     hi_reg, hi_next;
    logic [WORD_BITS-1:0]  rd_a_reg, rd_b_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic [1:0]            status_reg;

    logic [ADDR_W-1:0]    rd_a_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en, rd_en;
    logic [ADDR_W:0]      span;

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.few        = (count_reg < CNT_W'(2));
    assign stat.idx_beyond = (CMP_W'(s_data.read_index) >= CMP_W'(count_reg));
    assign span            = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign stat.rev_last   = (span <= (ADDR_W + 1)'(2));

    assign rd_en = cmd.pop || cmd.read || cmd.rev_read;

    always_comb begin
        if (cmd.pop) begin
            rd_a_addr = ADDR_W'(count_reg - 1'b1);
        end else if (cmd.read) begin
            rd_a_addr = ADDR_W'(s_data.read_index);
        end else begin
            rd_a_addr = lo_reg;
        end
    end

    always_comb begin
        wr_en   = cmd.push || cmd.rev_wr_lo || cmd.rev_wr_hi;
        wr_addr = ADDR_W'(count_reg);
        wr_data = WORD_BITS'(s_data.push_value);
        if (cmd.rev_wr_lo) begin
            wr_addr = lo_reg;
            wr_data = rd_b_reg;
        end else if (cmd.rev_wr_hi) begin
            wr_addr = hi_reg;
            wr_data = rd_a_reg;
        end
    end

    always_comb begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.rev_start) begin
            lo_next = '0;
            hi_next = ADDR_W'(count_reg - 1'b1);
        end else if (cmd.rev_wr_hi) begin
            lo_next = lo_reg + 1'b1;
            hi_next = hi_reg - 1'b1;
        end
    end

    // Both read ports hold their data until the next read command so that the
    // two swap writes see the values fetched before either was written.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[hi_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.out_load_mem) begin
            read_value_reg <= VALUE_BITS'(rd_a_reg);
            status_reg     <= cmd.st;
        end else if (cmd.out_load_zero) begin
            read_value_reg <= '0;
            status_reg     <= cmd.st;
        end
    end

    assign m_data.read_value = read_value_reg;
    assign m_data.status     = status_reg;
    assign m_data.depth_now  = DEPTH_NOW_BITS'(count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the stack depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !stat.full)
        else $error("push issued on a full stack");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rev_wr_lo || cmd.rev_wr_hi) |-> (lo_reg < hi_reg))
        else $error("reverse swap pointers crossed");
`endif

endmodule

/* src/lifo_stack_with_reverse_unit.sv */
// Top level of the LIFO stack with in-place reverse: controller plus datapath.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_data (func, push_value, read_index)
//   m_       out        m_valid / m_ready   m_data (read_value, status, depth_now)
//
// Push, every rejected operation and a reverse of fewer than two entries register their
// result in the cycle after the transaction; pop and read pass through S_MEM_WAIT, as the
// entry memory read is registered. A reverse of n entries swaps floor(n / 2) pairs, each
// read in S_REV_READ and written in S_REV_WR_LO and S_REV_WR_HI on the single memory
// write port. One operation is in flight at a time; a new transaction is taken in the
// cycle its predecessor's result is taken, and a stalled result holds its payload.
// Reset clears the entry count and the handshake state; memory contents are not cleared.
`timescale 1ns / 1ps

module lifo_stack_with_reverse_unit #(
    parameter int DEPTH     = lsr_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = lsr_pkg::WORD_BITS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lsr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lsr_pkg::out_t m_data
);
    import lsr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .stat    (stat),
        .cmd     (cmd),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    lsr_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the LIFO stack with in-place reverse unit.
`timescale 1ns / 1ps

module tb;
    import lsr_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 120;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Predicted state of the stack.
    logic [WORD_BITS_DEFAULT-1:0] stack_words [STACK_DEPTH];
    int   stack_fill = 0;
    out_t pending_results[$];

    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_pending = 1'b0;
    bit   filling = 1'b1;

    lifo_stack_with_reverse_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t apply_stack_op(in_t item);
        out_t res;
        int   lo;
        int   hi;
        logic [WORD_BITS_DEFAULT-1:0] tmp;
        res = '0;
        case (item.func)
            FUNC_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_words[stack_fill] = item.push_value;
                    stack_fill++;
                    res.status = ST_OK;
                end
            end
            FUNC_POP: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    res.read_value = stack_words[stack_fill];
                    res.status = ST_OK;
                end
            end
            FUNC_READ: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(item.read_index) >= stack_fill) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = stack_words[item.read_index];
                    res.status = ST_OK;
                end
            end
            default: begin
                lo = 0;
                hi = stack_fill - 1;
                while (lo < hi) begin
                    tmp = stack_words[lo];
                    stack_words[lo] = stack_words[hi];
                    stack_words[hi] = tmp;
                    lo++;
                    hi--;
                end
                res.status = ST_OK;
            end
        endcase
        res.depth_now = stack_fill[DEPTH_NOW_BITS-1:0];
        return res;
    endfunction

    function automatic in_t make_item(logic [1:0] func, logic [31:0] value, logic [5:0] idx);
        in_t item;
        item.func = func;
        item.push_value = value;
        item.read_index = idx;
        return item;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken,
    // with s_valid still high so a following item can go out back to back.
    task automatic send_item(input in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_stack_op(item));
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random stalls, plus an occasional long hold-off.
    always @(posedge aclk) begin : receiver
        int hold_left;
        if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_data.read_value, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_value !== want.read_value)
                    report_mismatch("read_value", m_data.read_value, want.read_value);
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                if (m_data.depth_now !== want.depth_now)
                    report_mismatch("depth_now", 32'(m_data.depth_now), 32'(want.depth_now));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic test_edge_cases();
        send_item(make_item(FUNC_POP, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd0));
        send_item(make_item(FUNC_REVERSE, 32'h0, 6'd0));
        send_item(make_item(FUNC_PUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(FUNC_REVERSE, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd1));
        send_item(make_item(FUNC_PUSH, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(FUNC_PUSH, 32'h1234_5678, 6'd0));
        // An odd entry count leaves the middle entry in place.
        send_item(make_item(FUNC_REVERSE, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(FUNC_READ, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd2));
        send_item(make_item(FUNC_READ, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(FUNC_PUSH, 32'hA5A5_5A5A, 6'd0));
        send_item(make_item(FUNC_REVERSE, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd1));
        send_item(make_item(FUNC_READ, 32'h0, 6'd3));
        repeat (5) send_item(make_item(FUNC_POP, 32'h0, 6'd0));
        release_input();
    endtask

    task automatic test_full_stack();
        while (stack_fill < STACK_DEPTH)
            send_item(make_item(FUNC_PUSH, $urandom, 6'($urandom_range(63))));
        send_item(make_item(FUNC_PUSH, 32'hFFFF_FFFF, 6'd0));
        send_item(make_item(FUNC_PUSH, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd63));
        send_item(make_item(FUNC_REVERSE, 32'h0, 6'd0));
        send_item(make_item(FUNC_READ, 32'h0, 6'd63));
        send_item(make_item(FUNC_READ, 32'h0, 6'd0));
        repeat (10) send_item(make_item(FUNC_POP, 32'h0, 6'd0));
        release_input();
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_pending = 1'b1;
        repeat (30) send_item(random_item());
        release_input();
    endtask

    function automatic in_t random_item();
        logic [1:0] func;
        logic [5:0] idx;
        int r;
        if (stack_fill == STACK_DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (stack_fill == 0 || $urandom_range(99) == 0)
            filling = (stack_fill == 0) ? 1'b1 : !filling;
        r = $urandom_range(99);
        if (filling)
            func = (r < 55) ? FUNC_PUSH : (r < 70) ? FUNC_POP : (r < 93) ? FUNC_READ
                                                                        : FUNC_REVERSE;
        else
            func = (r < 15) ? FUNC_PUSH : (r < 60) ? FUNC_POP : (r < 90) ? FUNC_READ
                                                                        : FUNC_REVERSE;
        if (stack_fill > 0 && $urandom_range(3) != 0)
            idx = 6'($urandom_range(stack_fill - 1));
        else
            idx = 6'($urandom_range(63));
        return make_item(func, $urandom, idx);
    endfunction

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_item(random_item());
        release_input();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_cases();
        test_full_stack();
        test_backpressure();
        test_random_phase(250, 0, 0);
        test_random_phase(250, 49, 0);
        test_random_phase(250, 0, 49);
        test_random_phase(250, 24, 24);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/lsr_pkg.sv
src/lsr_ctrl.sv
src/lsr_dpath.sv
src/lifo_stack_with_reverse_unit.sv
tb/tb.sv
